// ===== rtl/rpi_pkg.sv =====
// Shared constants and helpers for the ray/pyramid intersection block.
package rpi_pkg;

    localparam int WORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int HEIGHT_BITS    = 31;
    localparam int TOL_BITS       = 16;
    localparam int CFG_DATA_BITS  = HEIGHT_BITS;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(65536);
    localparam logic [TOL_BITS-1:0]    TOL_RESET    = TOL_BITS'(7);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HEIGHT,
        CFG_TOL
    } cfg_index_t;

    // Face order: (+,+), (-,+), (+,-), (-,-)
    localparam int CASE_BITS = 2;
    localparam logic [CASE_BITS-1:0] LAST_CASE = 2'd3;

    function automatic logic case_x_neg(input logic [CASE_BITS-1:0] idx);
        return idx[0];
    endfunction

    function automatic logic case_y_neg(input logic [CASE_BITS-1:0] idx);
        return idx[1];
    endfunction

endpackage

// ===== rtl/rpi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side-band tag.
module rpi_div #(
    parameter int W   = 32,
    parameter int F   = 16,
    parameter int MB  = 36,
    parameter int TAG = 197
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [MB-1:0]  num_mag,
    input  logic [MB-1:0]  den_mag,
    input  logic [TAG-1:0] in_tag,
    output logic           out_valid,
    output logic [W-1:0]   quotient,
    output logic [TAG-1:0] out_tag
);

    localparam int RB = MB + 1;
    localparam int NW = MB + F;

    logic [NW-1:0]  dividend;
    logic           v_reg   [W];
    logic [RB-1:0]  rem_reg [W];
    logic [W-1:0]   quo_reg [W];
    logic [W-1:0]   low_reg [W];
    logic [MB-1:0]  den_reg [W];
    logic [TAG-1:0] tag_reg [W];

    assign dividend = NW'(num_mag) << F;

    genvar s;
    generate
        for (s = 0; s < W; s++) begin : g_stage
            logic           v_in;
            logic [RB-1:0]  rem_in;
            logic [W-1:0]   quo_in;
            logic [W-1:0]   low_in;
            logic [MB-1:0]  den_in;
            logic [TAG-1:0] tag_in;
            logic [RB-1:0]  trial;
            logic           ge;

            if (s == 0) begin : g_first
                assign v_in   = in_valid;
                assign rem_in = RB'(dividend >> W);
                assign quo_in = '0;
                assign low_in = dividend[W-1:0];
                assign den_in = den_mag;
                assign tag_in = in_tag;
            end else begin : g_next
                assign v_in   = v_reg[s-1];
                assign rem_in = rem_reg[s-1];
                assign quo_in = quo_reg[s-1];
                assign low_in = low_reg[s-1];
                assign den_in = den_reg[s-1];
                assign tag_in = tag_reg[s-1];
            end

            // shift in the next dividend bit, subtract when it fits
            assign trial = {rem_in[RB-2:0], low_in[W-1-s]};
            assign ge    = (trial >= RB'(den_in));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else
                begin
                    v_reg[s] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= ge ? (trial - RB'(den_in)) : trial;
                quo_reg[s] <= {quo_in[W-2:0], ge};
                low_reg[s] <= low_in;
                den_reg[s] <= den_in;
                tag_reg[s] <= tag_in;
            end
        end
    endgenerate

    assign out_valid = v_reg[W-1];
    assign quotient  = quo_reg[W-1];
    assign out_tag   = tag_reg[W-1];

endmodule

// ===== rtl/ray_pyramid_intersection.sv =====
// Top level: ray against the four side faces of the pyramid z = h - |x| - |y|.
//
// Usage: present a ray on origin_* / dir_* with start high; it is taken at the
// clock edge where start is high and busy is low. Each ray is split into its
// four faces, which enter the pipeline on consecutive cycles; busy stays high
// while the issue counter steps through the faces and is low for the last one,
// so the next ray can be taken while earlier faces are still in the pipeline.
// Each face goes through: face setup, magnitude/overflow check, a divider of
// WORD_BITS single-bit stages, saturation, three multipliers, hit test.
// Results leave with valid high for one cycle: one per kept face in face
// order, or a single miss (hit low) when no face is kept; last marks the
// final result of a ray. The receiver cannot stall; results are delivered at
// up to one per cycle.
// height and zero_tolerance are written through cfg_we/cfg_index/cfg_data
// while the block is idle. Reset clears all valid bits and restores the
// register defaults (height 1.0, tolerance 7).
module ray_pyramid_intersection #(
    parameter int WORD_BITS = rpi_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [WORD_BITS-1:0]         origin_x,
    input  logic signed [WORD_BITS-1:0]         origin_y,
    input  logic signed [WORD_BITS-1:0]         origin_z,
    input  logic signed [WORD_BITS-1:0]         dir_x,
    input  logic signed [WORD_BITS-1:0]         dir_y,
    input  logic signed [WORD_BITS-1:0]         dir_z,
    input  logic                                cfg_we,
    input  logic [rpi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rpi_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                valid,
    output logic                                hit,
    output logic signed [WORD_BITS-1:0]         distance,
    output logic signed [WORD_BITS-1:0]         point_x,
    output logic signed [WORD_BITS-1:0]         point_y,
    output logic signed [WORD_BITS-1:0]         point_z,
    output logic                                normal_x_positive,
    output logic                                normal_y_positive,
    output logic                                last
);
    import rpi_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int EXT = (W > HEIGHT_BITS + 1) ? W : HEIGHT_BITS + 1;
    localparam int NB  = EXT + 2;
    localparam int RW  = 2 * W + 1;
    localparam int RAY = 6 * W;
    localparam int TAG = RAY + CASE_BITS + 3;
    localparam int CW  = NB + F + W;

    typedef struct packed {
        logic signed [W-1:0] t;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic                nx;
        logic                ny;
    } hit_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [RW-1:0] v);
        logic fits;
        fits = (v[RW-1:W-1] == '0) || (v[RW-1:W-1] == '1);
        if (fits)
            return v[W-1:0];
        return v[RW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    // configuration
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [TOL_BITS-1:0]    tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= HEIGHT_RESET;
            tol_reg    <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEIGHT: height_reg <= cfg_data[HEIGHT_BITS-1:0];
                CFG_TOL:    tol_reg    <= cfg_data[TOL_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // issue: one face per cycle from the held ray
    logic                 active_reg;
    logic [CASE_BITS-1:0] cnt_reg;
    logic signed [W-1:0]  px_reg, py_reg, pz_reg, dx_reg, dy_reg, dz_reg;
    logic                 accept;

    assign busy   = active_reg && (cnt_reg != LAST_CASE);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (accept)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            active_reg <= (cnt_reg != LAST_CASE);
            cnt_reg    <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= origin_x;
            py_reg <= origin_y;
            pz_reg <= origin_z;
            dx_reg <= dir_x;
            dy_reg <= dir_y;
            dz_reg <= dir_z;
        end
    end

    // stage 1: numerator and denominator of the face
    logic signed [NB-1:0] pxe, pye, pze, dxe, dye, dze, he;
    logic signed [NB-1:0] num_next, den_next;
    logic                 xn, yn;

    assign pxe = NB'(px_reg);
    assign pye = NB'(py_reg);
    assign pze = NB'(pz_reg);
    assign dxe = NB'(dx_reg);
    assign dye = NB'(dy_reg);
    assign dze = NB'(dz_reg);
    assign he  = signed'(NB'(height_reg));
    assign xn  = case_x_neg(cnt_reg);
    assign yn  = case_y_neg(cnt_reg);

    assign den_next = (xn ? -dxe : dxe) + (yn ? -dye : dye) + dze;
    assign num_next = he - (xn ? -pxe : pxe) - (yn ? -pye : pye) - pze;

    logic                 s1_valid_reg;
    logic signed [NB-1:0] s1_num_reg, s1_den_reg;
    logic [RAY-1:0]       s1_ray_reg;
    logic [CASE_BITS-1:0] s1_case_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_num_reg  <= num_next;
        s1_den_reg  <= den_next;
        s1_ray_reg  <= {px_reg, py_reg, pz_reg, dx_reg, dy_reg, dz_reg};
        s1_case_reg <= cnt_reg;
    end

    // stage 2: magnitudes, near-zero skip, quotient overflow
    logic          num_neg, den_neg, skip_next, ovf_next;
    logic [NB-1:0] nmag_next, dmag_next;
    logic [CW-1:0] nsh, dsh;

    assign num_neg   = s1_num_reg[NB-1];
    assign den_neg   = s1_den_reg[NB-1];
    assign nmag_next = num_neg ? NB'(-s1_num_reg) : NB'(s1_num_reg);
    assign dmag_next = den_neg ? NB'(-s1_den_reg) : NB'(s1_den_reg);
    assign skip_next = (dmag_next == '0) || (dmag_next < NB'(tol_reg));
    assign nsh       = CW'(nmag_next) << F;
    assign dsh       = CW'(dmag_next) << W;
    assign ovf_next  = (nsh >= dsh);

    logic           s2_valid_reg;
    logic [NB-1:0]  s2_nmag_reg, s2_dmag_reg;
    logic [TAG-1:0] s2_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_nmag_reg <= nmag_next;
        s2_dmag_reg <= dmag_next;
        s2_tag_reg  <= {s1_ray_reg, s1_case_reg, num_neg ^ den_neg, ovf_next, skip_next};
    end

    // divider
    logic           d_valid;
    logic [W-1:0]   d_quo;
    logic [TAG-1:0] d_tag;

    rpi_div #(
        .W   (W),
        .F   (F),
        .MB  (NB),
        .TAG (TAG)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .num_mag   (s2_nmag_reg),
        .den_mag   (s2_dmag_reg),
        .in_tag    (s2_tag_reg),
        .out_valid (d_valid),
        .quotient  (d_quo),
        .out_tag   (d_tag)
    );

    // stage T: sign and saturate t
    logic [RAY-1:0]       d_ray;
    logic [CASE_BITS-1:0] d_case;
    logic                 d_neg, d_ovf, d_skip;
    logic signed [W-1:0]  t_next;

    assign {d_ray, d_case, d_neg, d_ovf, d_skip} = d_tag;

    always_comb
    begin
        if (d_ovf)
            t_next = d_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else if (!d_neg)
            t_next = d_quo[W-1] ? {1'b0, {(W-1){1'b1}}} : signed'(d_quo);
        else if (d_quo[W-1] && (d_quo[W-2:0] != '0))
            t_next = {1'b1, {(W-1){1'b0}}};
        else
            t_next = -signed'(d_quo);
    end

    logic                 t_valid_reg, t_skip_reg;
    logic signed [W-1:0]  t_reg;
    logic [RAY-1:0]       t_ray_reg;
    logic [CASE_BITS-1:0] t_case_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
        end
        else
        begin
            t_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        t_skip_reg <= d_skip;
        t_ray_reg  <= d_ray;
        t_case_reg <= d_case;
    end

    // stage M: direction times t
    logic                  m_valid_reg, m_skip_reg;
    logic signed [2*W-1:0] m_px_reg, m_py_reg, m_pz_reg;
    logic signed [W-1:0]   m_t_reg, m_ox_reg, m_oy_reg, m_oz_reg;
    logic [CASE_BITS-1:0]  m_case_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= t_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_px_reg   <= signed'(t_ray_reg[3*W-1:2*W]) * t_reg;
        m_py_reg   <= signed'(t_ray_reg[2*W-1:W]) * t_reg;
        m_pz_reg   <= signed'(t_ray_reg[W-1:0]) * t_reg;
        m_ox_reg   <= signed'(t_ray_reg[6*W-1:5*W]);
        m_oy_reg   <= signed'(t_ray_reg[5*W-1:4*W]);
        m_oz_reg   <= signed'(t_ray_reg[4*W-1:3*W]);
        m_t_reg    <= t_reg;
        m_skip_reg <= t_skip_reg;
        m_case_reg <= t_case_reg;
    end

    // stage A: hit point and face test
    logic signed [RW-1:0] rx, ry, rz, h_ext;
    logic                 xpos, ypos, kept_next;
    hit_t                 hit_next;

    assign rx    = RW'(m_ox_reg) + RW'(m_px_reg >>> F);
    assign ry    = RW'(m_oy_reg) + RW'(m_py_reg >>> F);
    assign rz    = RW'(m_oz_reg) + RW'(m_pz_reg >>> F);
    assign h_ext = signed'(RW'(height_reg));
    assign xpos  = (rx > 0);
    assign ypos  = (ry > 0);

    assign kept_next = !m_skip_reg
                    && (xpos == !case_x_neg(m_case_reg))
                    && (ypos == !case_y_neg(m_case_reg))
                    && (rz > 0) && (rz < h_ext);

    assign hit_next = '{t: m_t_reg, x: sat_w(rx), y: sat_w(ry), z: sat_w(rz),
                        nx: xpos, ny: ypos};

    logic a_valid_reg, a_kept_reg, a_last_reg;
    hit_t a_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_kept_reg <= kept_next;
        a_last_reg <= (m_case_reg == LAST_CASE);
        a_hit_reg  <= hit_next;
    end

    // collector: hold one kept hit back until we know whether it is the last
    logic pend_v_reg, pend_v_next, tail_v_reg, tail_v_next;
    hit_t pend_reg, pend_next, tail_reg, tail_next;
    logic out_v_reg, out_v_next, out_hit_reg, out_hit_next, out_last_reg, out_last_next;
    hit_t out_reg, out_next;

    always_comb
    begin
        out_v_next    = 1'b0;
        out_hit_next  = 1'b0;
        out_last_next = 1'b0;
        out_next      = '0;
        pend_v_next   = pend_v_reg;
        pend_next     = pend_reg;
        tail_v_next   = 1'b0;
        tail_next     = tail_reg;

        if (tail_v_reg)
        begin
            out_v_next    = 1'b1;
            out_hit_next  = 1'b1;
            out_last_next = 1'b1;
            out_next      = tail_reg;
        end

        if (a_valid_reg)
        begin
            if (!a_last_reg)
            begin
                if (a_kept_reg)
                begin
                    if (pend_v_reg)
                    begin
                        out_v_next   = 1'b1;
                        out_hit_next = 1'b1;
                        out_next     = pend_reg;
                    end
                    pend_v_next = 1'b1;
                    pend_next   = a_hit_reg;
                end
            end
            else
            begin
                pend_v_next = 1'b0;
                if (a_kept_reg && pend_v_reg)
                begin
                    // two results due: send the held one now, the final one next cycle
                    out_v_next   = 1'b1;
                    out_hit_next = 1'b1;
                    out_next     = pend_reg;
                    tail_v_next  = 1'b1;
                    tail_next    = a_hit_reg;
                end
                else if (a_kept_reg)
                begin
                    out_v_next    = 1'b1;
                    out_hit_next  = 1'b1;
                    out_last_next = 1'b1;
                    out_next      = a_hit_reg;
                end
                else if (pend_v_reg)
                begin
                    out_v_next    = 1'b1;
                    out_hit_next  = 1'b1;
                    out_last_next = 1'b1;
                    out_next      = pend_reg;
                end
                else
                begin
                    out_v_next    = 1'b1;
                    out_last_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            tail_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            pend_v_reg <= pend_v_next;
            tail_v_reg <= tail_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        tail_reg     <= tail_next;
        out_reg      <= out_next;
        out_hit_reg  <= out_hit_next;
        out_last_reg <= out_last_next;
    end

    assign valid             = out_v_reg;
    assign hit               = out_hit_reg;
    assign last              = out_last_reg;
    assign distance          = out_reg.t;
    assign point_x           = out_reg.x;
    assign point_y           = out_reg.y;
    assign point_z           = out_reg.z;
    assign normal_x_positive = out_reg.nx;
    assign normal_y_positive = out_reg.ny;

endmodule

// ===== rtl/rpi_checker.sv =====
// Port-level checks for the ray/pyramid intersection block, bound to the top level.
module rpi_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic valid,
    input logic hit,
    input logic last
);

    // after a request is taken, busy is high until the last of its faces issues
    a_busy_window: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 busy ##1 busy ##1 !busy)
        else $error("busy window after a request is not three cycles");

    // a miss is never followed at once by another result
    a_gap_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !hit) |=> !valid)
        else $error("result directly after a miss result");

    // a miss is always the only and final result of its ray
    a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !hit) |-> last)
        else $error("miss result without last");

    // the issue slot is free right after reset
    a_idle_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !busy)
        else $error("busy after reset");

endmodule

bind ray_pyramid_intersection rpi_checker u_rpi_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ray/pyramid intersection block.
module tb;
    import rpi_pkg::*;

    typedef struct {
        logic        hit;
        logic [31:0] distance;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
        logic        nx_pos;
        logic        ny_pos;
        logic        last;
    } hit_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic valid, hit, normal_x_positive, normal_y_positive, last;
    logic signed [31:0] distance, point_x, point_y, point_z;

    hit_rec_t expected_hits[$];
    longint apex_h = 65536;
    longint den_tol = 7;
    int mismatches = 0;
    int rays_sent = 0;
    int hits_seen = 0;
    int misses_seen = 0;
    int idle_cycles = 0;
    localparam int IDLE_LIMIT = 5000;

    ray_pyramid_intersection uut (.*);

    always #5 clk = ~clk;

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor16(input longint v);
        return v >>> 16;
    endfunction

    // Compute the results of one ray against the four faces.
    task automatic trace_faces(input logic signed [31:0] px_i, py_i, pz_i,
                               dx_i, dy_i, dz_i);
        longint px, py, pz, dx, dy, dz, den, num, mag, t, rx, ry, rz;
        longint sa, sb;
        int count;
        hit_rec_t r;
        count = 0;
        px = px_i; py = py_i; pz = pz_i; dx = dx_i; dy = dy_i; dz = dz_i;
        for (int i = 0; i < 4; i++) begin
            sa = (i % 2 == 0) ? 1 : -1;
            sb = (i < 2) ? 1 : -1;
            den = sa * dx + sb * dy + dz;
            num = apex_h - sa * px - sb * py - pz;
            mag = den < 0 ? -den : den;
            if (den == 0 || mag < den_tol) continue;
            t = sat32((num * 65536) / den);
            rx = px + floor16(dx * t);
            ry = py + floor16(dy * t);
            rz = pz + floor16(dz * t);
            if ((rx > 0) != (sa > 0) || (ry > 0) != (sb > 0)) continue;
            if (!(rz > 0 && rz < apex_h)) continue;
            r.hit = 1'b1;
            r.distance = 32'(t);
            r.point_x = 32'(sat32(rx));
            r.point_y = 32'(sat32(ry));
            r.point_z = 32'(sat32(rz));
            r.nx_pos = rx > 0;
            r.ny_pos = ry > 0;
            r.last = 1'b0;
            expected_hits.push_back(r);
            count++;
        end
        if (count == 0) begin
            r = '{1'b0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1};
            expected_hits.push_back(r);
        end else begin
            expected_hits[expected_hits.size() - 1].last = 1'b1;
        end
    endtask

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g != 0) start <= 1'b0;
        repeat (g) @(negedge clk);
    endtask

    // Send one ray request and wait for acceptance; start stays high so the
    // next request can follow at once.
    task automatic send_ray(input logic signed [31:0] px, py, pz, dx, dy, dz);
        origin_x <= px; origin_y <= py; origin_z <= pz;
        dir_x <= dx; dir_y <= dy; dir_z <= dz;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        trace_faces(px, py, pz, dx, dy, dz);
        rays_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_hits.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [30:0] v);
        drain();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HEIGHT) apex_h = v;
        else den_tol = v[15:0];
    endtask

    function automatic logic [31:0] rand_coord(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic test_directed();
        send_ray(0, 0, 32'sh0002_0000, 0, 0, 32'shffff_0000);
        send_ray(32'sh0000_4000, 32'sh0000_4000, 0, 0, 0, 32'sh0001_0000);
        send_ray(-32'sh0000_4000, 32'sh0000_4000, 0, 0, 0, 32'sh0001_0000);
        send_ray(32'sh0000_4000, -32'sh0000_4000, 0, 0, 0, 32'sh0001_0000);
        send_ray(-32'sh0000_4000, -32'sh0000_4000, 0, 0, 0, 32'sh0001_0000);
        send_ray(32'sh0002_0000, 32'sh0000_2000, 32'sh0000_4000,
                 -32'sh0001_0000, 0, 0);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(0, 0, 0, 3, 2, 1);
        send_ray(0, 0, 0, 1, -1, 0);
        send_ray(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        send_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1);
        send_ray(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        send_ray(0, 0, 32'sh0000_8000, 32'sh0000_0010, 0, 32'sh0000_0001);
    endtask

    task automatic test_random(input int n, input int span);
        for (int i = 0; i < n; i++) begin
            random_gap();
            if ($urandom_range(0, 4) == 0)
                send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                send_ray(rand_coord(span), rand_coord(span), rand_coord(span),
                         rand_coord(span), rand_coord(span), rand_coord(span));
        end
    endtask

    // Compare each strobed result with the oldest expectation.
    always @(posedge clk) begin
        hit_rec_t e;
        if (rst_n && valid) begin
            if (hit) hits_seen++; else misses_seen++;
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                e = expected_hits.pop_front();
                if (hit !== e.hit || distance !== e.distance || point_x !== e.point_x
                    || point_y !== e.point_y || point_z !== e.point_z
                    || normal_x_positive !== e.nx_pos || normal_y_positive !== e.ny_pos
                    || last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %b %h %h %h %h %b%b %b got %b %h %h %h %h %b%b %b",
                                 e.hit, e.distance, e.point_x, e.point_y, e.point_z,
                                 e.nx_pos, e.ny_pos, e.last, hit, distance, point_x,
                                 point_y, point_z, normal_x_positive, normal_y_positive,
                                 last);
                end
            end
        end
    end

    // Abort when nothing moves for too long.
    always @(posedge clk) begin
        if (valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout");
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(40, 32'sh0002_0000);
        write_reg(CFG_HEIGHT, 31'h7fff_ffff);
        write_reg(CFG_TOL, 16'hffff);
        test_random(30, 32'sh0100_0000);
        write_reg(CFG_HEIGHT, 31'd0);
        write_reg(CFG_TOL, 16'd0);
        test_random(20, 32'sh0002_0000);
        write_reg(CFG_HEIGHT, 31'h0004_0000);
        write_reg(CFG_TOL, 16'd300);
        test_random(56, 32'sh0004_0000);
        drain();
        $display("rays %0d, hits %0d, misses %0d over four register settings",
                 rays_sent, hits_seen, misses_seen);
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d pending", mismatches, expected_hits.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
